// ===== rtl/z80rle_pkg.sv =====
// Shared types and constants for the Z80 snapshot ED ED run-length decoder.
package z80rle_pkg;

    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;
    localparam logic [7:0] ESC_BYTE = 8'hED;
    localparam int SLOTS = 3;
    localparam logic [3:0] PAGE_LOW = 4'd4;
    localparam logic [3:0] PAGE_HIGH = 4'd5;
    localparam logic [1:0] VERSION_SINGLE = 2'd1;

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_TRUNC    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ESC_IDLE  = 4'b0001,
        ESC_ONE   = 4'b0010,
        ESC_TWO   = 4'b0100,
        ESC_COUNT = 4'b1000
    } esc_phase_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  value;
        logic [7:0]  length;
        status_t     status;
    } res_t;

    typedef struct packed {
        res_t [SLOTS-1:0] slot;
        logic [1:0]       num;
    } res_bundle_t;

endpackage

// ===== rtl/z80rle_core.sv =====
// Escape state, address tracking and result generation for one compressed word.
module z80rle_core
    import z80rle_pkg::*;
#(
    parameter int MEMORY_BYTES = 49152,
    parameter int PAGE_BYTES = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic [3:0]  page_number,
    input  logic        first_byte,
    input  logic        last_byte,
    output res_bundle_t results
);

    localparam logic [CNT_W-1:0] MEM_C = CNT_W'(MEMORY_BYTES);
    localparam logic [CNT_W-1:0] PAGE_C = CNT_W'(PAGE_BYTES);
    localparam int PAGE2 = 2 * PAGE_BYTES;
    localparam logic [CNT_W-1:0] PAGE2_C = (PAGE2 > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(PAGE2);

    logic [1:0]       version_reg;
    esc_phase_t       phase_reg, phase_next;
    logic [7:0]       count_reg, count_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] prod_reg, prod_next;
    logic             ovf_reg, ovf_next;

    logic [CNT_W-1:0] start_addr, addr0, prod0, addr1, prod1;
    logic [CNT_W-1:0] avail_a;
    logic [CNT_W:0]   sum_addr_a, sum_prod_a, sum_addr_b, sum_prod_b;
    esc_phase_t       phase0, phase_after;
    logic [7:0]       count0;
    logic             ovf0;
    logic             run_a, run_b;
    logic [7:0]       val_a, len_a, val_b;
    logic             emit_a, emit_b, clip_a, ovf_a, ovf_b;
    logic [7:0]       out_len_a;
    logic [CNT_W-1:0] expected;
    status_t          status;
    res_t             res_a, res_b, res_s;
    res_t [SLOTS-1:0] slots;
    logic [1:0]       k;

    always_comb begin
        start_addr = '0;
        if (version_reg > VERSION_SINGLE) begin
            if (page_number == PAGE_LOW) begin
                start_addr = PAGE_C;
            end else if (page_number == PAGE_HIGH) begin
                start_addr = PAGE2_C;
            end
        end
        addr0  = first_byte ? start_addr : addr_reg;
        prod0  = first_byte ? '0 : prod_reg;
        ovf0   = first_byte ? 1'b0 : ovf_reg;
        phase0 = first_byte ? ESC_IDLE : phase_reg;
        count0 = first_byte ? 8'd0 : count_reg;
    end

    // Decode the escape sequence into at most two runs.
    always_comb begin
        run_a = 1'b0;
        run_b = 1'b0;
        val_a = data_byte;
        len_a = 8'd1;
        val_b = data_byte;
        count_next = count0;
        phase_after = phase0;
        case (phase0)
            ESC_IDLE: begin
                if (data_byte == ESC_BYTE) begin
                    phase_after = ESC_ONE;
                end else begin
                    run_a = 1'b1;
                end
            end
            ESC_ONE: begin
                if (data_byte == ESC_BYTE) begin
                    phase_after = ESC_TWO;
                end else begin
                    run_a = 1'b1;
                    val_a = ESC_BYTE;
                    run_b = 1'b1;
                    phase_after = ESC_IDLE;
                end
            end
            ESC_TWO: begin
                count_next = data_byte;
                phase_after = ESC_COUNT;
            end
            ESC_COUNT: begin
                run_a = (count0 != 8'd0);
                len_a = count0;
                phase_after = ESC_IDLE;
            end
            default: begin
                phase_after = ESC_IDLE;
            end
        endcase
    end

    // First run: clip at the end of memory, advance counters by the full length.
    always_comb begin
        avail_a    = MEM_C - addr0;
        emit_a     = run_a && (addr0 < MEM_C);
        clip_a     = {9'd0, len_a} > avail_a;
        out_len_a  = clip_a ? avail_a[7:0] : len_a;
        ovf_a      = run_a && ((addr0 >= MEM_C) || clip_a);
        sum_addr_a = {1'b0, addr0} + (CNT_W+1)'(len_a);
        sum_prod_a = {1'b0, prod0} + (CNT_W+1)'(len_a);
        addr1 = addr0;
        prod1 = prod0;
        if (run_a) begin
            addr1 = sum_addr_a[CNT_W] ? CNT_MAX : sum_addr_a[CNT_W-1:0];
            prod1 = sum_prod_a[CNT_W] ? CNT_MAX : sum_prod_a[CNT_W-1:0];
        end
    end

    // Second run is always one byte long.
    always_comb begin
        emit_b     = run_b && (addr1 < MEM_C);
        ovf_b      = run_b && (addr1 >= MEM_C);
        sum_addr_b = {1'b0, addr1} + (CNT_W+1)'(1);
        sum_prod_b = {1'b0, prod1} + (CNT_W+1)'(1);
        addr_next = addr1;
        prod_next = prod1;
        if (run_b) begin
            addr_next = sum_addr_b[CNT_W] ? CNT_MAX : sum_addr_b[CNT_W-1:0];
            prod_next = sum_prod_b[CNT_W] ? CNT_MAX : sum_prod_b[CNT_W-1:0];
        end
        ovf_next = ovf0 || ovf_a || ovf_b;
    end

    always_comb begin
        expected = (version_reg == VERSION_SINGLE) ? MEM_C : PAGE_C;
        if (phase_after != ESC_IDLE) begin
            status = ST_TRUNC;
        end else if (ovf_next) begin
            status = ST_OVERFLOW;
        end else if (prod_next != expected) begin
            status = ST_BAD_LEN;
        end else begin
            status = ST_OK;
        end
        phase_next = last_byte ? ESC_IDLE : phase_after;
    end

    // Pack the results that occur so that they come out in order.
    always_comb begin
        res_a = '{kind: KIND_RUN, address: addr0[15:0], value: val_a,
                  length: out_len_a, status: ST_OK};
        res_b = '{kind: KIND_RUN, address: addr1[15:0], value: val_b,
                  length: 8'd1, status: ST_OK};
        res_s = '{kind: KIND_STATUS, address: 16'd0, value: 8'd0,
                  length: 8'd0, status: status};
        slots = '0;
        k = 2'd0;
        if (emit_a) begin
            slots[k] = res_a;
            k = k + 2'd1;
        end
        if (emit_b) begin
            slots[k] = res_b;
            k = k + 2'd1;
        end
        if (last_byte) begin
            slots[k] = res_s;
            k = k + 2'd1;
        end
        results.slot = slots;
        results.num  = k;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= VERSION_SINGLE;
            phase_reg   <= ESC_IDLE;
            count_reg   <= 8'd0;
            addr_reg    <= '0;
            prod_reg    <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                version_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                addr_reg  <= addr_next;
                prod_reg  <= prod_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_byte |=> phase_reg == ESC_IDLE)
        else $error("escape state not idle after the last word of a block");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_byte |-> results.slot[results.num - 2'd1].kind == KIND_STATUS)
        else $error("status result is not the final result of its word");

    a_addr_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !first_byte |=> addr_reg >= $past(addr_reg))
        else $error("write address moved backward within a block");

endmodule

// ===== rtl/z80rle_outbuf.sv =====
// Result register that holds the results of one word and hands them out in order.
module z80rle_outbuf
    import z80rle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  res_bundle_t results,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        out_res,
    output logic        out_last
);

    res_t [SLOTS-1:0] slot_reg;
    logic [1:0]       rd_reg;
    logic [1:0]       cnt_reg;
    logic             load, take;

    assign out_valid = (cnt_reg != 2'd0);
    assign take      = out_valid && out_ready;
    // The next word may enter while the final pending result leaves.
    assign in_ready  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign load      = in_valid && in_ready;
    assign out_res   = slot_reg[rd_reg];
    assign out_last  = (cnt_reg == 2'd1);

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= results.slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= 2'd0;
            cnt_reg <= 2'd0;
        end else if (load) begin
            rd_reg  <= 2'd0;
            cnt_reg <= results.num;
        end else if (take) begin
            rd_reg  <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> ({1'b0, rd_reg} + {1'b0, cnt_reg}) <= 3'd3)
        else $error("read pointer beyond the stored results");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load && (results.num != 2'd0) |=> out_valid && (rd_reg == 2'd0))
        else $error("loaded results not presented");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !load |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("pending count did not drop after a transfer");

endmodule

// ===== rtl/z80rle_top.sv =====
// Z80 snapshot ED ED decoder: turns compressed bytes into memory write runs.
//
// Input channel (s_*): one compressed word per transfer with its page number
// and first/last block markers. Output channel (m_*): run results carrying
// address, value and length, and one status result after the last word of a
// block. m_last_result marks the final result caused by an input word.
// A word causes zero to three results. The results of a word appear in the cycle
// after it is accepted and leave at one per cycle while m_ready is high; a word
// causing at most one result can be accepted every cycle while m_ready is high,
// and one causing more holds the three-entry result register until all leave.
// While the receiver stalls, the pending results hold and s_ready stays low
// whenever any result is waiting; it rises again in the cycle in which the
// final pending result leaves.
// cfg_wr_en writes format_version (1: single 48K block, 2/3: paged blocks);
// write it only while the decoder is idle.
// Reset clears the escape state, address, counters and pending results and
// sets format_version to 1.
module z80_snapshot_rle_decoder_top
    import z80rle_pkg::*;
#(
    parameter int MEMORY_BYTES = 49152,
    parameter int PAGE_BYTES = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [3:0]  s_page_number,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_item_kind,
    output logic [15:0] m_run_address,
    output logic [7:0]  m_run_value,
    output logic [7:0]  m_run_length,
    output logic [1:0]  m_block_status,
    output logic        m_last_result
);

    res_bundle_t results;
    res_t        out_res;
    logic        accept;

    assign accept = s_valid && s_ready;

    z80rle_core #(
        .MEMORY_BYTES(MEMORY_BYTES),
        .PAGE_BYTES(PAGE_BYTES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .accept     (accept),
        .data_byte  (s_data_byte),
        .page_number(s_page_number),
        .first_byte (s_first_byte),
        .last_byte  (s_last_byte),
        .results    (results)
    );

    z80rle_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .results  (results),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_res  (out_res),
        .out_last (m_last_result)
    );

    assign m_item_kind    = out_res.kind;
    assign m_run_address  = out_res.address;
    assign m_run_value    = out_res.value;
    assign m_run_length   = out_res.length;
    assign m_block_status = out_res.status;

endmodule
